// ----- rtl/fpsc_pkg.sv -----
// Constants and quarter-wave table for the fixed-point sine/cosine pipeline.
package fpsc_pkg;

   localparam int AngleWidth = 32;
   localparam int ValueWidth = 18;

   localparam int TauWidth = 35;
   localparam int RedWidth = 37;
   localparam int FineWidth = 38;
   localparam logic [TauWidth-1:0] Tau = 35'd26986075409;

   // floor(angle * 2^16 / Tau) ~ (angle * RecipQ) >> RecipQShift
   localparam logic [30:0] RecipQ = 31'd1367130551;
   localparam int RecipQShift = 49;
   // floor(red * 2^16 / Tau) ~ (red[34:3] * RecipP) >> RecipPShift
   localparam logic [31:0] RecipP = 32'd2734261102;
   localparam int RecipPShift = 47;

   localparam logic [15:0] QuarterTurn = 16'd16384;
   localparam logic [5:0] FracHalf = 6'd32;
   localparam logic [8:0] LastIndex = 9'd256;

   typedef enum logic [0:0] {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } op_type;

   localparam logic [16:0] QuarterWave [0:256] = '{
      17'd0, 17'd402, 17'd804, 17'd1206, 17'd1608, 17'd2010, 17'd2412, 17'd2814,
      17'd3216, 17'd3617, 17'd4019, 17'd4420, 17'd4821, 17'd5222, 17'd5623, 17'd6023,
      17'd6424, 17'd6824, 17'd7224, 17'd7623, 17'd8022, 17'd8421, 17'd8820, 17'd9218,
      17'd9616, 17'd10014, 17'd10411, 17'd10808, 17'd11204, 17'd11600, 17'd11996,
      17'd12391,
      17'd12785, 17'd13180, 17'd13573, 17'd13966, 17'd14359, 17'd14751, 17'd15143,
      17'd15534,
      17'd15924, 17'd16314, 17'd16703, 17'd17091, 17'd17479, 17'd17867, 17'd18253,
      17'd18639,
      17'd19024, 17'd19409, 17'd19792, 17'd20175, 17'd20557, 17'd20939, 17'd21320,
      17'd21699,
      17'd22078, 17'd22457, 17'd22834, 17'd23210, 17'd23586, 17'd23961, 17'd24335,
      17'd24708,
      17'd25080, 17'd25451, 17'd25821, 17'd26190, 17'd26558, 17'd26925, 17'd27291,
      17'd27656,
      17'd28020, 17'd28383, 17'd28745, 17'd29106, 17'd29466, 17'd29824, 17'd30182,
      17'd30538,
      17'd30893, 17'd31248, 17'd31600, 17'd31952, 17'd32303, 17'd32652, 17'd33000,
      17'd33347,
      17'd33692, 17'd34037, 17'd34380, 17'd34721, 17'd35062, 17'd35401, 17'd35738,
      17'd36075,
      17'd36410, 17'd36744, 17'd37076, 17'd37407, 17'd37736, 17'd38064, 17'd38391,
      17'd38716,
      17'd39040, 17'd39362, 17'd39683, 17'd40002, 17'd40320, 17'd40636, 17'd40951,
      17'd41264,
      17'd41576, 17'd41886, 17'd42194, 17'd42501, 17'd42806, 17'd43110, 17'd43412,
      17'd43713,
      17'd44011, 17'd44308, 17'd44604, 17'd44898, 17'd45190, 17'd45480, 17'd45769,
      17'd46056,
      17'd46341, 17'd46624, 17'd46906, 17'd47186, 17'd47464, 17'd47741, 17'd48015,
      17'd48288,
      17'd48559, 17'd48828, 17'd49095, 17'd49361, 17'd49624, 17'd49886, 17'd50146,
      17'd50404,
      17'd50660, 17'd50914, 17'd51166, 17'd51417, 17'd51665, 17'd51911, 17'd52156,
      17'd52398,
      17'd52639, 17'd52878, 17'd53114, 17'd53349, 17'd53581, 17'd53812, 17'd54040,
      17'd54267,
      17'd54491, 17'd54714, 17'd54934, 17'd55152, 17'd55368, 17'd55582, 17'd55794,
      17'd56004,
      17'd56212, 17'd56418, 17'd56621, 17'd56823, 17'd57022, 17'd57219, 17'd57414,
      17'd57607,
      17'd57798, 17'd57986, 17'd58172, 17'd58356, 17'd58538, 17'd58718, 17'd58896,
      17'd59071,
      17'd59244, 17'd59415, 17'd59583, 17'd59750, 17'd59914, 17'd60075, 17'd60235,
      17'd60392,
      17'd60547, 17'd60700, 17'd60851, 17'd60999, 17'd61145, 17'd61288, 17'd61429,
      17'd61568,
      17'd61705, 17'd61839, 17'd61971, 17'd62101, 17'd62228, 17'd62353, 17'd62476,
      17'd62596,
      17'd62714, 17'd62830, 17'd62943, 17'd63054, 17'd63162, 17'd63268, 17'd63372,
      17'd63473,
      17'd63572, 17'd63668, 17'd63763, 17'd63854, 17'd63944, 17'd64031, 17'd64115,
      17'd64197,
      17'd64277, 17'd64354, 17'd64429, 17'd64501, 17'd64571, 17'd64639, 17'd64704,
      17'd64766,
      17'd64827, 17'd64884, 17'd64940, 17'd64993, 17'd65043, 17'd65091, 17'd65137,
      17'd65180,
      17'd65220, 17'd65259, 17'd65294, 17'd65328, 17'd65358, 17'd65387, 17'd65413,
      17'd65436,
      17'd65457, 17'd65476, 17'd65492, 17'd65505, 17'd65516, 17'd65525, 17'd65531,
      17'd65535,
      17'd65536
   };

endpackage

// ----- rtl/fixed_point_sine_cosine_top.sv -----
// Seven-stage pipelined fixed-point sine/cosine unit.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid req_ready req_operation       | in
//           | req_angle                               |
//   result  | rsp_valid rsp_ready rsp_value           | out
//
// One word enters per cycle while the pipeline is not stalled.
// The stages: quotient estimate, reduction, correction, phase estimate,
// phase residue, table lookup, interpolation and sign.
// Reset clears the stage valid bits only; data registers keep stale values.
// A stage holds while the one after it is full and stalled; the stall
// ripples back to req_ready, so no word is dropped or repeated.
module fixed_point_sine_cosine_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic signed [fpsc_pkg::AngleWidth-1:0] req_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [fpsc_pkg::ValueWidth-1:0] rsp_value
);
   import fpsc_pkg::*;

   logic [7:1] valid_ff, valid_in;
   logic [7:1] adv;

   logic [AngleWidth-1:0] ang1_ff;
   logic signed [13:0] q1_ff, q1_in;
   op_type op1_ff, op2_ff, op3_ff, op4_ff, op5_ff;
   logic signed [RedWidth-1:0] r2_ff, r2_in;
   logic [TauWidth-1:0] red3_ff, red3_in, red4_ff;
   logic [16:0] pe4_ff, pe4_in, pe5_ff;
   logic signed [FineWidth-1:0] rr5_ff, rr5_in;
   logic [16:0] base6_ff, base6_in;
   logic [8:0] diff6_ff, diff6_in;
   logic [5:0] frac6_ff, frac6_in;
   logic sign6_ff, sign6_in;
   logic signed [ValueWidth-1:0] value7_ff, value7_in;

   logic signed [63:0] prod1;
   logic signed [50:0] qtau2, diff2;
   logic [63:0] prod4;
   logic signed [52:0] rr5_full;
   logic [16:0] phase17;
   logic [15:0] phase16;
   logic [14:0] pos6;
   logic [8:0] idx6, idxn6;
   logic [14:0] interp7;
   logic [16:0] mag7;

   // stall chain: a stage moves when empty or when its successor moves
   always_comb begin
      adv[7] = !valid_ff[7] || rsp_ready;
      for (int k = 6; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in = {valid_ff[6:1], req_valid};
   assign req_ready = adv[1];

   // stage 1: quotient estimate of angle*2^16 / Tau
   assign prod1 = $signed(64'(req_angle)) * $signed(64'(RecipQ));
   assign q1_in = prod1[RecipQShift+13:RecipQShift];

   // stage 2: residue with the estimated quotient, off by at most one Tau
   assign qtau2 = $signed(51'(q1_ff)) * $signed(51'(Tau));
   assign diff2 = $signed({{3{ang1_ff[AngleWidth-1]}}, ang1_ff, 16'd0}) - qtau2;
   assign r2_in = diff2[RedWidth-1:0];

   // stage 3: bring the residue into 0..Tau-1
   always_comb begin
      if (r2_ff[RedWidth-1]) begin
         red3_in = TauWidth'(r2_ff + $signed(RedWidth'(Tau)));
      end else if (r2_ff >= $signed(RedWidth'(Tau))) begin
         red3_in = TauWidth'(r2_ff - $signed(RedWidth'(Tau)));
      end else begin
         red3_in = TauWidth'(r2_ff);
      end
   end

   // stage 4: phase estimate red*2^16/Tau
   assign prod4 = 64'(red3_ff[TauWidth-1:3]) * 64'(RecipP);
   assign pe4_in = prod4[RecipPShift+16:RecipPShift];

   // stage 5: residue of the phase estimate
   assign rr5_full = $signed(53'({red4_ff, 16'd0})) - $signed(53'(pe4_ff) * 53'(Tau));
   assign rr5_in = rr5_full[FineWidth-1:0];

   // stage 6: exact phase, quadrant fold, table reads
   always_comb begin
      phase17 = pe5_ff;
      if (rr5_ff[FineWidth-1]) begin
         phase17 = pe5_ff - 17'd1;
      end else if (rr5_ff >= $signed(FineWidth'(Tau))) begin
         phase17 = pe5_ff + 17'd1;
      end
      phase16 = phase17[15:0];
      if (op5_ff == OP_COSINE) begin
         phase16 = phase17[15:0] + QuarterTurn;
      end
      pos6 = {1'b0, phase16[13:0]};
      if (phase16[14]) begin
         pos6 = 15'(QuarterTurn) - {1'b0, phase16[13:0]};
      end
      idx6 = pos6[14:6];
      idxn6 = (idx6 == LastIndex) ? LastIndex : idx6 + 9'd1;
      base6_in = QuarterWave[idx6];
      diff6_in = 9'(QuarterWave[idxn6] - QuarterWave[idx6]);
      frac6_in = pos6[5:0];
      sign6_in = phase16[15];
   end

   // stage 7: rounded interpolation and sign
   assign interp7 = 15'(diff6_ff) * 15'(frac6_ff) + 15'(FracHalf);
   assign mag7 = base6_ff + 17'(interp7[14:6]);
   assign value7_in = sign6_ff ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= 7; k++) begin
            if (adv[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         ang1_ff <= req_angle;
         q1_ff <= q1_in;
         op1_ff <= op_type'(req_operation);
      end
      if (adv[2]) begin
         r2_ff <= r2_in;
         op2_ff <= op1_ff;
      end
      if (adv[3]) begin
         red3_ff <= red3_in;
         op3_ff <= op2_ff;
      end
      if (adv[4]) begin
         red4_ff <= red3_ff;
         pe4_ff <= pe4_in;
         op4_ff <= op3_ff;
      end
      if (adv[5]) begin
         rr5_ff <= rr5_in;
         pe5_ff <= pe4_ff;
         op5_ff <= op4_ff;
      end
      if (adv[6]) begin
         base6_ff <= base6_in;
         diff6_ff <= diff6_in;
         frac6_ff <= frac6_in;
         sign6_ff <= sign6_in;
      end
      if (adv[7]) begin
         value7_ff <= value7_in;
      end
   end

   assign rsp_valid = valid_ff[7];
   assign rsp_value = value7_ff;

   reduced_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> red3_ff < Tau)
      else $error("reduced angle out of range");

   quotient_within_one: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (r2_ff >= -$signed(RedWidth'(Tau)))
                      && (r2_ff < $signed(RedWidth'(Tau)) + $signed(RedWidth'(Tau))))
      else $error("quotient estimate off by more than one");

   phase_within_one: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> (rr5_ff >= -$signed(FineWidth'(Tau)))
                      && (rr5_ff < $signed(FineWidth'(Tau)) + $signed(FineWidth'(Tau))))
      else $error("phase estimate off by more than one");

   value_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value >= -18'sd65536) && (rsp_value <= 18'sd65536))
      else $error("result out of range");

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the fixed-point sine/cosine unit: directed and random angles.
`timescale 1ns / 1ps

module tb_top;
   import fpsc_pkg::*;

   localparam longint TauQ32 = 64'sd26986075409;
   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = 1'b0;
   logic signed [31:0] req_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [17:0] rsp_value;

   logic [17:0] expected_values[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit stall_enable = 1'b1;
   bit gap_enable = 1'b1;

   fixed_point_sine_cosine_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_angle(req_angle),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_value(rsp_value)
   );

   always #10 clock = ~clock;

   // Quarter-wave magnitude per sin(i*pi/512), read from the package table with no math calls.
   function automatic logic [16:0] wave_entry(int unsigned idx);
      wave_entry = QuarterWave[idx];
   endfunction

   function automatic logic [17:0] trig_value(op_type op, logic signed [31:0] angle);
      longint reduced;
      logic [63:0] prod;
      logic [15:0] phase;
      logic [15:0] pos;
      int unsigned idx;
      int unsigned frac;
      logic [17:0] mag;
      int unsigned step;
      reduced = (longint'(angle) * 65536) % TauQ32;
      if (reduced < 0) reduced += TauQ32;
      prod = (64'(reduced) * 64'd65536) / 64'(TauQ32);
      phase = prod[15:0];
      if (op == OP_COSINE) phase = phase + 16'd16384;
      pos = {2'b00, phase[13:0]};
      if (phase[14]) pos = 16'd16384 - pos;
      idx = pos >> 6;
      frac = pos & 63;
      mag = {1'b0, wave_entry(idx)};
      if (frac != 0 && idx < 256) begin
         step = wave_entry(idx + 1) - wave_entry(idx);
         mag = mag + 18'((step * frac + 32) >> 6);
      end
      if (phase[15]) mag = -mag;
      return mag;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
      return $urandom_range(0, 2);
   endfunction

   // Hold valid across a zero gap; drop it only while idling.
   task automatic send_angle(op_type op, logic signed [31:0] angle);
      int gap;
      gap = gap_enable ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_angle <= angle;
      expected_values.push_back(trig_value(op, angle));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Receiver: stall at random while stalls are enabled, check each accepted word.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result %0d", rsp_value);
            end else begin
               if (rsp_value !== expected_values[0]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("value mismatch: expected %0d got %0d",
                              $signed(expected_values[0]), rsp_value);
               end
               void'(expected_values.pop_front());
            end
         end
         rsp_ready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_extremes();
      op_type op;
      for (int k = 0; k < 2; k++) begin
         op = op_type'(k);
         send_angle(op, 32'sh0000_0000);
         send_angle(op, 32'sh7FFF_FFFF);
         send_angle(op, 32'sh8000_0000);
         send_angle(op, 32'shFFFF_FFFF);
         send_angle(op, 32'sh0000_0001);
         // near pi/2 (sine peak), pi, negative pi/2 and 2*pi
         send_angle(op, 32'sd102944);
         send_angle(op, 32'sd205887);
         send_angle(op, -32'sd102944);
         send_angle(op, 32'sd411775);
         send_angle(op, -32'sd1);
      end
   endtask

   task automatic test_random_back_to_back();
      stall_enable = 1'b0;
      gap_enable = 1'b0;
      repeat (100) send_angle(op_type'($urandom_range(0, 1)), $urandom);
      stall_enable = 1'b1;
      gap_enable = 1'b1;
   endtask

   task automatic test_random_mixed();
      logic signed [31:0] angle;
      repeat (500) begin
         case ($urandom_range(0, 2))
            0: angle = $urandom;
            // small angles within a few turns hit every quadrant finely
            1: angle = $signed($urandom_range(0, 1300000)) - 32'sd650000;
            default: angle = $signed($urandom_range(0, 65535)) - 32'sd32768;
         endcase
         send_angle(op_type'($urandom_range(0, 1)), angle);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random_mixed();
      test_random_back_to_back();
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
